[design/sbda_pkg.sv]
// shared types and constants for the signed binary to decimal ascii converter
package sbda_pkg;

    localparam int VALUE_W   = 64;
    localparam int NUM_DIGITS = 19;
    localparam int BCD_W     = 4 * NUM_DIGITS;
    localparam int BITCNT_W  = $clog2(VALUE_W);
    localparam int DIGCNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [BITCNT_W-1:0] LAST_BIT   = BITCNT_W'(VALUE_W - 1);
    localparam logic [DIGCNT_W-1:0] ALL_DIGITS = DIGCNT_W'(NUM_DIGITS);
    localparam logic [DIGCNT_W-1:0] ONE_DIGIT  = DIGCNT_W'(1);

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CONV  = 5'b00010,
        ST_SKIP  = 5'b00100,
        ST_SIGN  = 5'b01000,
        ST_DIGIT = 5'b10000
    } state_t;

    typedef struct packed {
        logic load;
        logic convert;
        logic skip;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic one_left;
        logic negative;
        logic slot_free;
    } status_t;

endpackage

[design/sbda_ctrl.sv]
// sequencing state machine for the decimal converter
module sbda_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sbda_pkg::status_t status,
    output sbda_pkg::cmd_t    cmd
);

    sbda_pkg::state_t state_reg;
    sbda_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != sbda_pkg::ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            sbda_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sbda_pkg::ST_CONV;
                end
            end
            sbda_pkg::ST_CONV:
            begin
                cmd.convert = 1'b1;
                if (status.conv_done)
                begin
                    state_next = sbda_pkg::ST_SKIP;
                end
            end
            sbda_pkg::ST_SKIP:
            begin
                // drop leading zero digits, always keep the last one
                if (status.top_zero && !status.one_left)
                begin
                    cmd.skip = 1'b1;
                end
                else if (status.negative)
                begin
                    state_next = sbda_pkg::ST_SIGN;
                end
                else
                begin
                    state_next = sbda_pkg::ST_DIGIT;
                end
            end
            sbda_pkg::ST_SIGN:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = sbda_pkg::ST_DIGIT;
                end
            end
            sbda_pkg::ST_DIGIT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.one_left)
                    begin
                        state_next = sbda_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sbda_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[design/sbda_datapath.sv]
// magnitude, shift-and-add-3 digit register and output word register
module sbda_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sbda_pkg::VALUE_W-1:0]  value,
    input  sbda_pkg::cmd_t                cmd,
    output sbda_pkg::status_t             status,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    text_char,
    output logic                          last_char
);

    logic [sbda_pkg::VALUE_W-1:0]  mag_reg;
    logic [sbda_pkg::VALUE_W-1:0]  mag_next;
    logic [sbda_pkg::BCD_W-1:0]    bcd_reg;
    logic [sbda_pkg::BCD_W-1:0]    bcd_next;
    logic [sbda_pkg::BCD_W-1:0]    bcd_adj;
    logic [sbda_pkg::BITCNT_W-1:0] bitcnt_reg;
    logic [sbda_pkg::BITCNT_W-1:0] bitcnt_next;
    logic [sbda_pkg::DIGCNT_W-1:0] digleft_reg;
    logic [sbda_pkg::DIGCNT_W-1:0] digleft_next;
    logic                          neg_reg;
    logic                          neg_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [7:0]                    char_reg;
    logic [7:0]                    char_next;
    logic                          last_reg;
    logic                          last_next;
    logic [3:0]                    top_digit;

    assign top_digit = bcd_reg[sbda_pkg::BCD_W-1 -: 4];

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < sbda_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        bitcnt_next  = bitcnt_reg;
        digleft_next = digleft_reg;
        neg_next     = neg_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        if (cmd.load)
        begin
            neg_next     = value[sbda_pkg::VALUE_W-1];
            mag_next     = value[sbda_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
            bcd_next     = '0;
            bitcnt_next  = '0;
            digleft_next = sbda_pkg::ALL_DIGITS;
        end
        if (cmd.convert)
        begin
            bcd_next    = {bcd_adj[sbda_pkg::BCD_W-2:0], mag_reg[sbda_pkg::VALUE_W-1]};
            mag_next    = {mag_reg[sbda_pkg::VALUE_W-2:0], 1'b0};
            bitcnt_next = bitcnt_reg + 1'b1;
        end
        if (cmd.skip || cmd.emit_digit)
        begin
            bcd_next     = {bcd_reg[sbda_pkg::BCD_W-5:0], 4'd0};
            digleft_next = digleft_reg - 1'b1;
        end
        if (cmd.emit_sign)
        begin
            char_next = sbda_pkg::ASCII_MINUS;
            last_next = 1'b0;
        end
        if (cmd.emit_digit)
        begin
            char_next = sbda_pkg::ASCII_ZERO + {4'd0, top_digit};
            last_next = (digleft_reg == sbda_pkg::ONE_DIGIT);
        end
    end

    assign out_valid_next = (cmd.emit_sign || cmd.emit_digit) ? 1'b1
                                                              : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            neg_reg       <= 1'b0;
            digleft_reg   <= '0;
            bitcnt_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            neg_reg       <= neg_next;
            digleft_reg   <= digleft_next;
            bitcnt_reg    <= bitcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.conv_done = (bitcnt_reg == sbda_pkg::LAST_BIT);
    assign status.top_zero  = (top_digit == 4'd0);
    assign status.one_left  = (digleft_reg == sbda_pkg::ONE_DIGIT);
    assign status.negative  = neg_reg;
    assign status.slot_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign text_char = char_reg;
    assign last_char = last_reg;

    // a new word is only written into a free output slot
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_sign || cmd.emit_digit) |-> status.slot_free)
        else $error("word written over a pending output word");

    // the sign word is never the last of a run
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && char_reg == sbda_pkg::ASCII_MINUS) |-> !last_reg)
        else $error("minus sign marked as last word");

    // every output word is a minus sign or a decimal digit
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (char_reg == sbda_pkg::ASCII_MINUS ||
                           (char_reg >= sbda_pkg::ASCII_ZERO &&
                            char_reg <= sbda_pkg::ASCII_NINE)))
        else $error("output word is not a digit or minus sign");

    // digits are never emitted while the conversion is still running
    a_digit_after_conv: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_digit |-> !cmd.convert && digleft_reg != '0)
        else $error("digit emitted with no digits left");

endmodule

[design/signed_binary_to_decimal_ascii.sv]
// top level of the signed 64-bit binary to decimal ascii converter
//
// input channel: one word per number, a signed 64-bit value on value,
// taken when in_valid is high and in_stall is low
// output channel: one word per character on text_char, most significant
// first, with last_char high on the final digit of each number; a
// negative number starts with '-', zero gives a single '0'
// sequence: after a value is taken, shift-and-add-3 runs one step per
// magnitude bit; then leading zero digits are dropped one at a time (up
// to 18) before the sign or first digit is picked; then one character
// goes out per cycle while the receiver keeps out_stall low
// in_stall is high from acceptance until the last character is loaded
// into the output register, so the next value can be taken while that
// character still waits on the output side
// out_stall high holds a pending output word and pauses the output run
// reset clears the controller and the output valid; digit registers
// hold no reset value and are cleared when a value is taken
module signed_binary_to_decimal_ascii (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [sbda_pkg::VALUE_W-1:0] value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   text_char,
    output logic                         last_char
);

    // commands from the controller, status back from the datapath
    sbda_pkg::cmd_t    cmd;
    sbda_pkg::status_t status;

    // sequencer: idle, convert, strip leading zeros, sign, digits
    sbda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // magnitude register, 19-digit bcd register and output word register
    sbda_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .text_char (text_char),
        .last_char (last_char)
    );

endmodule

[tb/signed_binary_to_decimal_ascii_tb.sv]
// testbench for the signed 64-bit binary to decimal ascii converter
`timescale 1ns / 100ps

module signed_binary_to_decimal_ascii_tb;

    // one expected output word: a character and its end-of-number mark
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_word_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [sbda_pkg::VALUE_W-1:0]  value;
    logic                          out_valid;
    logic                          out_stall;
    logic [7:0]                    text_char;
    logic                          last_char;

    // characters still owed by the block, oldest first
    text_word_t pending_chars[$];
    int         mismatch_count = 0;

    // idle odds in percent for each side, changed per phase
    int         send_idle_pct;
    int         stall_pct;

    signed_binary_to_decimal_ascii uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .text_char (text_char),
        .last_char (last_char)
    );

    // 20 ns period
    always #10 clk = ~clk;

    // receiver side: random stall at the chosen rate, none when the rate is zero
    always @(posedge clk)
    begin
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // works out the decimal text of one value and queues its characters
    // magnitude is taken as unsigned, so the most negative value keeps all 19 digits
    function automatic void queue_decimal_text(input logic [sbda_pkg::VALUE_W-1:0] v);
        logic [sbda_pkg::VALUE_W-1:0] mag;
        logic [3:0]                   digits [sbda_pkg::NUM_DIGITS];
        int                           ndig;
        text_word_t                   w;
        mag  = v[sbda_pkg::VALUE_W-1] ? (~v + 64'd1) : v;
        ndig = 0;
        // zero still yields one digit
        if (mag == 64'd0)
        begin
            digits[0] = 4'd0;
            ndig      = 1;
        end
        while (mag != 64'd0 && ndig < sbda_pkg::NUM_DIGITS)
        begin
            digits[ndig] = 4'(mag % 64'd10);
            mag          = mag / 64'd10;
            ndig++;
        end
        // sign never carries the last mark, a digit always follows it
        if (v[sbda_pkg::VALUE_W-1])
        begin
            w.ch   = sbda_pkg::ASCII_MINUS;
            w.last = 1'b0;
            pending_chars.push_back(w);
        end
        for (int k = ndig - 1; k >= 0; k--)
        begin
            w.ch   = sbda_pkg::ASCII_ZERO + 8'(digits[k]);
            w.last = (k == 0);
            pending_chars.push_back(w);
        end
    endfunction

    // sends one word; valid is left high on return so back-to-back words
    // need no second assignment in the same step
    task automatic send_value(input logic [sbda_pkg::VALUE_W-1:0] v);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        // in_stall read here is the pre-edge value, so acceptance is race free
        do
            @(posedge clk);
        while (in_stall);
        queue_decimal_text(v);
    endtask

    // compares every accepted output word with the oldest expected one
    always @(posedge clk)
    begin : check_chars
        text_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected word: text_char %h last_char %b", text_char, last_char);
                mismatch_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (text_char !== want.ch)
                begin
                    $error("text_char: expected %h, got %h", want.ch, text_char);
                    mismatch_count++;
                end
                if (last_char !== want.last)
                begin
                    $error("last_char: expected %b, got %b", want.last, last_char);
                    mismatch_count++;
                end
            end
        end
    end

    // field extremes, digit-count boundaries and the special cases:
    // zero, the most negative value, and the sign lead-in
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_value(64'd0);
        send_value(64'd1);
        send_value(-64'sd1);
        send_value(64'd9);
        send_value(64'd10);
        send_value(-64'sd10);
        send_value(64'd99);
        send_value(64'd100);
        send_value(64'h7FFF_FFFF_FFFF_FFFF);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'h8000_0000_0000_0001);
        send_value(64'd999_999_999_999_999_999);
        send_value(64'd1_000_000_000_000_000_000);
        send_value(-64'sd1_000_000_000_000_000_000);
        send_value(64'h5555_5555_5555_5555);
        send_value(64'hAAAA_AAAA_AAAA_AAAA);
        send_value(64'd0);
        send_value(-64'sd9);
    endtask

    // random words in one idle setting; magnitudes spread over all digit counts
    task automatic run_random_phase(input int send_pct, input int rx_pct, input int count);
        logic [sbda_pkg::VALUE_W-1:0] v;
        logic [sbda_pkg::VALUE_W-1:0] p;
        send_idle_pct = send_pct;
        stall_pct     = rx_pct;
        repeat (count)
        begin
            v = {$urandom, $urandom};
            case ($urandom_range(3))
                0: ;  // full width, every bit random
                1: v = v >> $urandom_range(63);
                2: v = -(v >> $urandom_range(63));
                default:
                begin
                    // just around a power of ten, where the digit count changes
                    p = 64'd1;
                    repeat ($urandom_range(18)) p = p * 64'd10;
                    v = p + 64'($urandom_range(2)) - 64'd1;
                    if ($urandom_range(1))
                        v = -v;
                end
            endcase
            send_value(v);
        end
    endtask

    task automatic test_no_idle();
        run_random_phase(0, 0, 108);
    endtask

    task automatic test_sender_idle();
        run_random_phase(69, 0, 108);
    endtask

    task automatic test_receiver_stall();
        run_random_phase(0, 69, 108);
    endtask

    task automatic test_both_idle();
        run_random_phase(29, 29, 108);
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        value          = '0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();

        in_valid <= 1'b0;
        // drain, then leave room for any stray word
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (mismatch_count == 0 && pending_chars.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
